// File: hw/rtl/page_bitmap_allocator_unit_assert.svh
// Assertion macros for the page bitmap allocator checker.
// Needs nothing else; take it in with a plain include of the bare file name.
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Check a property on every rising edge, ignored while the reset term is true.
`define PBA_ASSERT(lbl, ck, rst, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PBA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: hw/rtl/pba_pkg.sv
// Shared types and constants of the page bitmap allocator.
// No dependencies; used by the top level and the checker.
package pba_pkg;

  localparam int MAX_PAGES_DEF     = 16384;
  localparam int MAP_WORD_BITS_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int FIRST_W  = 14;
  localparam int COUNT_W  = 15;
  localparam int CFG_W    = 15;

  localparam logic [CFG_W-1:0] ACTIVE_PAGES_RST = 15'd16384;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_RESERVE = 3'd2,
    OP_COUNT   = 3'd3,
    OP_CLEAR   = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [FIRST_W-1:0]  base_page;
    logic [COUNT_W-1:0]  num_pages;
  } pba_in_t;

  typedef struct packed {
    logic               status;
    logic [FIRST_W-1:0] start_page;
    logic [COUNT_W-1:0] used_count;
  } pba_out_t;

endpackage

// File: hw/rtl/pba_map_ram.sv
// Page usage map storage: one write port, one read port, registered read.
// No dependencies.
module pba_map_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/pba_word_unit.sv
// Shared word unit: masks, population count, free-run search and
// read-modify-write of one map word. Purely combinational, no dependencies.
module pba_word_unit #(
  parameter int MAX_PAGES     = 16384,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic [MAP_WORD_BITS-1:0]                rd_word,
  input  logic [$clog2(MAX_PAGES/MAP_WORD_BITS)-1:0] word_idx,
  input  logic [(($clog2(MAX_PAGES)+1) > 16 ? $clog2(MAX_PAGES)+2 : 17)-1:0] lim,
  input  logic [(($clog2(MAX_PAGES)+1) > 16 ? $clog2(MAX_PAGES)+2 : 17)-1:0] lo,
  input  logic [(($clog2(MAX_PAGES)+1) > 16 ? $clog2(MAX_PAGES)+2 : 17)-1:0] hi,
  input  logic [(($clog2(MAX_PAGES)+1) > 16 ? $clog2(MAX_PAGES)+2 : 17)-1:0] run_need,
  input  logic [(($clog2(MAX_PAGES)+1) > 16 ? $clog2(MAX_PAGES)+2 : 17)-1:0] carry_in,
  input  logic                                    set_bits,
  output logic [MAP_WORD_BITS-1:0]                new_word,
  output logic [$clog2(MAP_WORD_BITS):0]          pop,
  output logic                                    found,
  output logic [$clog2(MAP_WORD_BITS)-1:0]        found_bit,
  output logic [(($clog2(MAX_PAGES)+1) > 16 ? $clog2(MAX_PAGES)+2 : 17)-1:0] run_top
);

  localparam int WB     = MAP_WORD_BITS;
  localparam int BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int ADDR_W = $clog2(MAX_PAGES / MAP_WORD_BITS);
  localparam int PAGE_W = $clog2(MAX_PAGES) + 1;
  localparam int CW     = (PAGE_W > 16) ? PAGE_W + 1 : 17;
  localparam int POP_W  = BIT_W + 1;

  // Bits of this word whose page number lies below the bound.
  function automatic logic [WB-1:0] below_mask(input logic [ADDR_W-1:0] idx,
                                               input logic [CW-1:0] bound);
    logic [CW-BIT_W-1:0] bw;
    logic [BIT_W-1:0]    bb;
    logic [CW-BIT_W-1:0] iw;
    bw = bound[CW-1:BIT_W];
    bb = bound[BIT_W-1:0];
    iw = (CW-BIT_W)'(idx);
    if (iw < bw) begin
      below_mask = '1;
    end else if (iw == bw) begin
      below_mask = ~({WB{1'b1}} << bb);
    end else begin
      below_mask = '0;
    end
  endfunction

  logic [WB-1:0]    active_w;
  logic [WB-1:0]    range_w;
  logic [WB-1:0]    free_w;
  logic [WB-1:0]    has_used;
  logic [BIT_W-1:0] used_idx [WB];
  logic [CW-1:0]    run_len  [WB];
  logic [WB-1:0]    hit;

  assign active_w = below_mask(word_idx, lim);
  assign range_w  = below_mask(word_idx, hi) & ~below_mask(word_idx, lo);
  assign new_word = set_bits ? (rd_word | range_w) : (rd_word & ~range_w);
  // pages past the active limit break any run
  assign free_w   = ~rd_word & active_w;

  always_comb begin
    pop = '0;
    for (int b = 0; b < WB; b++) begin
      pop = pop + POP_W'(rd_word[b] & active_w[b]);
    end
  end

  // Run length ending at each bit: distance to the nearest used bit at or
  // below it, or, when there is none, the carried run from earlier words plus the bits up to it.
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      has_used[b] = 1'b0;
      used_idx[b] = '0;
      for (int j = 0; j <= b; j++) begin
        if (!free_w[j]) begin
          has_used[b] = 1'b1;
          used_idx[b] = BIT_W'(j);
        end
      end
      if (has_used[b]) begin
        run_len[b] = CW'(b) - CW'(used_idx[b]);
      end else begin
        run_len[b] = carry_in + CW'(b) + CW'(1);
      end
      hit[b] = (run_len[b] >= run_need);
    end
  end

  always_comb begin
    found_bit = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (hit[b]) begin
        found_bit = BIT_W'(b);
      end
    end
  end

  assign found   = |hit;
  assign run_top = run_len[WB-1];

endmodule

// File: hw/rtl/page_bitmap_allocator_unit.sv
// Page bitmap allocator, top level: sequencer, map memory and word unit.
// Depends on pba_pkg, pba_map_ram and pba_word_unit.
//
// One request word at a time; in_ready is high only while the sequencer is
// idle, and a finished result may wait in the output register while the next
// word is taken. All timing is set by the map memory, one word of
// MAP_WORD_BITS pages per cycle (N = MAX_PAGES / MAP_WORD_BITS = 512 words by
// default). After reset all N map words are cleared before the first word is
// accepted. Count reads the words up to the active page limit; allocate
// searches those words for a free run and then marks the words the run spans
// with a read-modify-write; free and reserve do the same over their range;
// clear writes all N words; a rejected request, or one that touches no active
// page, goes straight to the result.
module page_bitmap_allocator_unit #(
  parameter int MAX_PAGES     = pba_pkg::MAX_PAGES_DEF,
  parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pba_pkg::pba_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pba_pkg::pba_out_t        out_data,
  input  logic                     cfg_wr_en,
  input  logic [pba_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int MAP_WORDS = MAX_PAGES / MAP_WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int PAGE_W    = $clog2(MAX_PAGES) + 1;
  localparam int CW        = (PAGE_W > 16) ? PAGE_W + 1 : 17;
  localparam int POP_W     = BIT_W + 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_CLEAR,
    S_RESP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ADDR_W-1:0]             addr_r, addr_nxt;
  logic [ADDR_W-1:0]             last_r, last_nxt;
  logic [ADDR_W-1:0]             dw_r, dw_nxt;
  logic                          iss_r, iss_nxt;
  logic                          dv_r, dv_nxt;
  logic [CW-1:0]                 carry_r, carry_nxt;
  logic [CW-1:0]                 acc_r, acc_nxt;
  logic [CW-1:0]                 lo_r, lo_nxt;
  logic [CW-1:0]                 hi_r, hi_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          set_r, set_nxt;
  logic [pba_pkg::OPCODE_W-1:0]  op_r, op_nxt;
  logic [pba_pkg::CFG_W-1:0]     act_r, act_nxt;
  pba_pkg::pba_out_t             res_r, res_nxt;
  pba_pkg::pba_out_t             out_data_r, out_data_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          mem_rd_en;
  logic [MAP_WORD_BITS-1:0]      mem_rd_data;
  logic                          mem_wr_en;
  logic [ADDR_W-1:0]             mem_wr_addr;
  logic [MAP_WORD_BITS-1:0]      mem_wr_data;

  logic [MAP_WORD_BITS-1:0]      wu_new_word;
  logic [POP_W-1:0]              wu_pop;
  logic                          wu_found;
  logic [BIT_W-1:0]              wu_found_bit;
  logic [CW-1:0]                 wu_run_top;

  logic [CW-1:0]                 lim;
  logic [CW-1:0]                 lim_m1;
  logic [CW-1:0]                 in_first;
  logic [CW-1:0]                 in_cnt;
  logic [CW-1:0]                 run_end;
  logic [CW-1:0]                 clip_hi;
  logic [CW-1:0]                 clip_m1;
  logic [CW-1:0]                 fstart;
  logic [CW-1:0]                 fend;
  logic [CW-1:0]                 fend_m1;
  logic [CW-1:0]                 acc_sum;

  assign lim      = (CW'(act_r) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(act_r);
  assign lim_m1   = lim - CW'(1);
  assign in_first = CW'(in_data.base_page);
  assign in_cnt   = CW'(in_data.num_pages);
  assign run_end  = in_first + in_cnt;
  assign clip_hi  = (run_end > lim) ? lim : run_end;
  assign clip_m1  = clip_hi - CW'(1);
  // the run ends at the hit bit
  assign fend_m1  = CW'({dw_r, wu_found_bit});
  assign fend     = fend_m1 + CW'(1);
  assign fstart   = fend - count_r;
  assign acc_sum  = acc_r + CW'(wu_pop);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pba_map_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (addr_r),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  pba_word_unit #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_word (
    .rd_word   (mem_rd_data),
    .word_idx  (dw_r),
    .lim       (lim),
    .lo        (lo_r),
    .hi        (hi_r),
    .run_need  (count_r),
    .carry_in  (carry_r),
    .set_bits  (set_r),
    .new_word  (wu_new_word),
    .pop       (wu_pop),
    .found     (wu_found),
    .found_bit (wu_found_bit),
    .run_top   (wu_run_top)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    iss_nxt       = iss_r;
    carry_nxt     = carry_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    count_nxt     = count_r;
    set_nxt       = set_r;
    op_nxt        = op_r;
    act_nxt       = cfg_wr_en ? cfg_wr_data : act_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dv_nxt        = 1'b0;
    dw_nxt        = addr_r;
    mem_rd_en     = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = addr_r;
    mem_wr_data   = '0;

    case (state_r)
      S_INIT: begin
        mem_wr_en = 1'b1;
        addr_nxt  = addr_r + ADDR_W'(1);
        if (addr_r == ADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          op_nxt    = in_data.opcode;
          count_nxt = in_cnt;
          carry_nxt = '0;
          acc_nxt   = '0;
          iss_nxt   = 1'b0;
          case (in_data.opcode)
            pba_pkg::OP_ALLOC, pba_pkg::OP_COUNT: begin
              if (lim == '0 ||
                  (in_data.opcode == pba_pkg::OP_ALLOC && in_cnt == '0)) begin
                res_nxt.status = (in_data.opcode == pba_pkg::OP_ALLOC);
                state_nxt      = S_RESP;
              end else begin
                addr_nxt  = '0;
                last_nxt  = lim_m1[BIT_W +: ADDR_W];
                iss_nxt   = 1'b1;
                set_nxt   = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            pba_pkg::OP_FREE, pba_pkg::OP_RESERVE: begin
              if (in_data.opcode == pba_pkg::OP_FREE &&
                  (in_first == '0 || in_cnt == '0)) begin
                res_nxt.status = 1'b1;
                state_nxt      = S_RESP;
              end else if (clip_hi <= in_first) begin
                // nothing inside the active pages
                state_nxt = S_RESP;
              end else begin
                lo_nxt    = in_first;
                hi_nxt    = clip_hi;
                addr_nxt  = in_first[BIT_W +: ADDR_W];
                last_nxt  = clip_m1[BIT_W +: ADDR_W];
                set_nxt   = (in_data.opcode == pba_pkg::OP_RESERVE);
                iss_nxt   = 1'b1;
                state_nxt = S_WRITE;
              end
            end
            pba_pkg::OP_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              res_nxt.status = 1'b1;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_SCAN, S_WRITE: begin
        // issue the next read while the previous word is processed
        mem_rd_en = iss_r;
        dv_nxt    = iss_r;
        if (iss_r) begin
          addr_nxt = addr_r + ADDR_W'(1);
          if (addr_r == last_r) begin
            iss_nxt = 1'b0;
          end
        end
        if (dv_r) begin
          if (state_r == S_WRITE) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dw_r;
            mem_wr_data = wu_new_word;
            if (dw_r == last_r) begin
              state_nxt = S_RESP;
            end
          end else if (op_r == pba_pkg::OP_ALLOC) begin
            if (wu_found) begin
              // switch to marking the run; drop the read in flight
              res_nxt.start_page = fstart[pba_pkg::FIRST_W-1:0];
              lo_nxt    = fstart;
              hi_nxt    = fend;
              addr_nxt  = fstart[BIT_W +: ADDR_W];
              last_nxt  = fend_m1[BIT_W +: ADDR_W];
              iss_nxt   = 1'b1;
              dv_nxt    = 1'b0;
              state_nxt = S_WRITE;
            end else begin
              carry_nxt = wu_run_top;
              if (dw_r == last_r) begin
                res_nxt.status = 1'b1;
                state_nxt      = S_RESP;
              end
            end
          end else begin
            acc_nxt = acc_sum;
            if (dw_r == last_r) begin
              res_nxt.used_count = acc_sum[pba_pkg::COUNT_W-1:0];
              state_nxt          = S_RESP;
            end
          end
        end
      end

      S_CLEAR: begin
        mem_wr_en = 1'b1;
        addr_nxt  = addr_r + ADDR_W'(1);
        if (addr_r == ADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      addr_r      <= '0;
      iss_r       <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= pba_pkg::ACTIVE_PAGES_RST;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
    end
    last_r     <= last_nxt;
    dw_r       <= dw_nxt;
    carry_r    <= carry_nxt;
    acc_r      <= acc_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    count_r    <= count_nxt;
    set_r      <= set_nxt;
    op_r       <= op_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: hw/rtl/pba_checker.sv
// Port-level checks for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg and page_bitmap_allocator_unit_assert.svh.
`include "page_bitmap_allocator_unit_assert.svh"

module pba_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pba_pkg::pba_out_t out_data
);

  // hold a stalled result word
  `PBA_ASSERT(a_out_hold, clk, !rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")

  // one request at a time: busy right after taking a word
  `PBA_ASSERT(a_busy_after_take, clk, !rst_n, in_valid && in_ready |=> !in_ready, "request word taken while busy")

  // a failed or rejected request carries no page number and no count
  `PBA_ASSERT(a_fail_clean, clk, !rst_n, out_valid && out_data.status |-> out_data.start_page == 0 && out_data.used_count == 0, "failed result carries data")

  // reset drops the result and starts the map clearing sweep
  `PBA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid && !in_ready, "block not quiet after reset")

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
